// ===== sv/stenc_pkg.sv =====
// shared types, byte codes and helper functions for the track encoder
package stenc_pkg;

  localparam int MAX_RES = 32;

  localparam logic [7:0] B_FE = 8'hFE;
  localparam logic [7:0] B_7F = 8'h7F;
  localparam logic [7:0] B_80 = 8'h80;
  localparam logic [7:0] B_FF = 8'hFF;
  localparam logic [7:0] B_2E = 8'h2E;
  localparam logic [7:0] B_2D = 8'h2D;
  localparam logic [7:0] B_2F = 8'h2F;
  localparam logic [7:0] B_00 = 8'h00;

  localparam logic [1:0] REG_LOOP_EN   = 2'd0;
  localparam logic [1:0] REG_LOOP_PT   = 2'd1;
  localparam logic [1:0] REG_SONG_LEN  = 2'd2;

  localparam logic FUNC_EVENT  = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef struct packed {
    logic        start;
    logic [31:0] byte_count;
    logic [31:0] resume;
    logic [3:0]  dlen;
    logic [5:0]  olen;
  } bo_cmd_t;

  typedef struct packed {
    logic        done;
    logic [5:0]  pre;
    logic [31:0] back;
  } bo_rsp_t;

  // number of 7-bit groups, at most nine
  function automatic logic [3:0] vlq_groups(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int k = 1; k < 9; k++) begin
      if ((v >> (7 * k)) != 64'd0) n = 4'(k + 1);
    end
    return n;
  endfunction

  function automatic logic [6:0] vlq_group(input logic [63:0] v, input logic [3:0] i);
    logic [6:0] g;
    g = 7'd0;
    for (int k = 0; k < 9; k++) begin
      if (i == 4'(k)) g = v[7 * k +: 7];
    end
    return g;
  endfunction

  function automatic logic [7:0] ls_byte(input logic [3:0] i);
    logic [7:0] b;
    case (i)
      4'd0:    b = B_FF;
      4'd1:    b = B_2E;
      4'd2:    b = B_00;
      default: b = B_FF;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [3:0] i, input logic lp,
                                           input logic [31:0] back);
    logic [7:0] b;
    if (!lp) begin
      b = (i == 4'd0) ? B_FF : B_2F;
    end else begin
      case (i)
        4'd0:    b = B_FF;
        4'd1:    b = B_2D;
        4'd2:    b = B_FF;
        4'd3:    b = B_FF;
        4'd4:    b = back[31:24];
        4'd5:    b = back[23:16];
        4'd6:    b = back[15:8];
        4'd7:    b = back[7:0];
        4'd8:    b = B_00;
        4'd9:    b = B_FF;
        default: b = B_2F;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== sv/stenc_backoff.sv =====
// iterative back offset unit: finds the number of delta prefixes that keeps 0xFE out, up to a limit
module stenc_backoff (
  input  logic              clk,
  input  logic              rst,
  input  stenc_pkg::bo_cmd_t cmd,
  output stenc_pkg::bo_rsp_t rsp
);
  import stenc_pkg::*;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_ADD  = 2'd1;
  localparam logic [1:0] U_CHK  = 2'd2;

  logic [1:0]        phase;
  logic [31:0]       acc;
  logic [5:0]        pre;
  logic signed [7:0] maxpre;
  logic [3:0]        dlen;
  logic              done;
  logic              has_fe;

  assign has_fe = (acc[31:24] == B_FE) || (acc[23:16] == B_FE) ||
                  (acc[15:8] == B_FE) || (acc[7:0] == B_FE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        U_IDLE: begin
          if (cmd.start) begin
            acc    <= cmd.byte_count - cmd.resume;
            pre    <= 6'd0;
            dlen   <= cmd.dlen;
            maxpre <= $signed(8'd21) - $signed({2'b00, cmd.olen}) -
                      $signed({4'b0000, cmd.dlen});
            phase  <= U_ADD;
          end
        end
        U_ADD: begin
          acc   <= acc + 32'(dlen) + 32'd8;
          phase <= U_CHK;
        end
        U_CHK: begin
          if (has_fe && ($signed({2'b00, pre}) < maxpre)) begin
            acc <= acc + 32'd1;
            pre <= pre + 6'd1;
          end else begin
            done  <= 1'b1;
            phase <= U_IDLE;
          end
        end
        default: phase <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.pre  = pre;
  assign rsp.back = acc;

endmodule

// ===== sv/sequence_track_encoder.sv =====
// top level of the track encoder: config registers, byte sequencer and output stage
//
// Encodes one track's events into a byte stream, one byte per cycle at most. An event
// item is taken in S_IDLE and decoded in S_DEC, then emits its bytes one by one (delta
// groups, loop-start marker, message bytes with 0xFE doubled) and hands over its last
// byte in S_FLUSH; each byte can be held by a stalled output. A finish item also sets
// up the end delta in S_ELD; with looping it then waits in S_BO1 and S_SCAN while the
// back offset unit tries 0x80 prefixes.
// The byte sequencer handles one item at a time, so in_ready is high only when it is
// idle; results are held in an output register while the next byte is prepared.
module sequence_track_encoder #(
  parameter int TICK_BITS     = 32,
  parameter int MAX_MSG_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] tick,
  input  logic [1:0]  order,
  input  logic [3:0]  msg_len,
  input  logic [7:0]  msg_b0,
  input  logic [7:0]  msg_b1,
  input  logic [7:0]  msg_b2,
  input  logic [7:0]  msg_b3,
  input  logic [7:0]  msg_b4,
  input  logic [7:0]  msg_b5,
  input  logic [7:0]  msg_b6,
  input  logic [7:0]  msg_b7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last
);
  import stenc_pkg::*;

  localparam int TW = TICK_BITS;
  localparam int MW = MAX_MSG_BYTES;
  localparam int IW = $clog2(MAX_MSG_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_LSV   = 4'd2;
  localparam logic [3:0] S_LSM   = 4'd3;
  localparam logic [3:0] S_EV    = 4'd4;
  localparam logic [3:0] S_MSG   = 4'd5;
  localparam logic [3:0] S_ELD   = 4'd6;
  localparam logic [3:0] S_BO1   = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_PRE   = 4'd9;
  localparam logic [3:0] S_EDV   = 4'd10;
  localparam logic [3:0] S_TAIL  = 4'd11;
  localparam logic [3:0] S_FLUSH = 4'd12;

  logic [3:0]    st;
  logic          loop_en;
  logic [31:0]   loop_pt;
  logic [31:0]   song_len;

  logic          is_fin;
  logic [TW-1:0] c_tick;
  logic [1:0]    c_ord;
  logic [3:0]    c_n;
  logic [7:0]    c_msg [MW];
  logic [7:0]    in_bytes [8];

  logic [TW-1:0] prev_tick;
  logic [31:0]   byte_count;
  logic [31:0]   resume_offset;
  logic          marker_done;
  logic          past_end;

  logic [TW-1:0] vlq_val;
  logic          vlq_first;
  logic [3:0]    vlq_idx;
  logic [3:0]    cnt;
  logic [IW-1:0] msg_idx;
  logic          dbl;
  logic [5:0]    pre_left;
  logic [5:0]    olen;
  logic          pend_valid;
  logic [7:0]    pend_byte;

  bo_cmd_t       bo_cmd;
  bo_rsp_t       bo_rsp;

  logic [TW-1:0] lp_m;
  logic [TW-1:0] len_m;
  logic [TW-1:0] eff_lp;
  logic [TW-1:0] tgt;
  logic [TW-1:0] delta;
  logic          need_ls;
  logic          drop;
  logic [3:0]    cur_idx;
  logic [7:0]    vbyte;
  logic          vdone;
  logic [7:0]    mb;
  logic          msg_last;
  logic [3:0]    tail_last;
  logic [7:0]    gen_byte;
  logic          gen_on;
  logic          out_free;
  logic          fire;
  logic          out_load;

  assign in_bytes[0] = msg_b0;
  assign in_bytes[1] = msg_b1;
  assign in_bytes[2] = msg_b2;
  assign in_bytes[3] = msg_b3;
  assign in_bytes[4] = msg_b4;
  assign in_bytes[5] = msg_b5;
  assign in_bytes[6] = msg_b6;
  assign in_bytes[7] = msg_b7;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == S_IDLE);

  assign lp_m   = TW'(loop_pt);
  assign len_m  = TW'(song_len);
  assign eff_lp = (lp_m > len_m) ? len_m : lp_m;

  assign need_ls = loop_en && !marker_done &&
                   (is_fin || (c_tick > eff_lp) || ((c_tick == eff_lp) && c_ord[1]));
  assign drop    = !is_fin && (past_end || (c_tick >= len_m));

  always_comb begin
    case (st)
      S_DEC:   tgt = need_ls ? eff_lp : c_tick;
      S_ELD:   tgt = len_m;
      default: tgt = c_tick;
    endcase
  end
  assign delta = (tgt >= prev_tick) ? (tgt - prev_tick) : '0;

  assign cur_idx = vlq_first ? (vlq_groups(64'(vlq_val)) - 4'd1) : vlq_idx;
  assign vbyte   = {(cur_idx != 4'd0), vlq_group(64'(vlq_val), cur_idx)};
  assign vdone   = (cur_idx == 4'd0);

  assign mb        = c_msg[msg_idx];
  assign msg_last  = (msg_idx == IW'(c_n - 4'd1));
  assign tail_last = loop_en ? 4'd10 : 4'd1;

  always_comb begin
    gen_on   = 1'b1;
    case (st)
      S_LSV, S_EV, S_EDV: gen_byte = vbyte;
      S_LSM:              gen_byte = ls_byte(cnt);
      S_MSG:              gen_byte = dbl ? B_FE : mb;
      S_PRE:              gen_byte = B_80;
      S_TAIL:             gen_byte = tail_byte(cnt, loop_en, bo_rsp.back);
      default: begin
        gen_byte = B_00;
        gen_on   = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid || out_ready;
  assign fire     = gen_on && (!pend_valid || out_free);
  assign out_load = (fire && pend_valid) || ((st == S_FLUSH) && out_free);

  assign bo_cmd.start      = (st == S_BO1);
  assign bo_cmd.byte_count = byte_count;
  assign bo_cmd.resume     = resume_offset;
  assign bo_cmd.dlen       = vlq_groups(64'(vlq_val));
  assign bo_cmd.olen       = olen;

  stenc_backoff u_backoff (
    .clk (clk),
    .rst (rst),
    .cmd (bo_cmd),
    .rsp (bo_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      loop_en       <= 1'b0;
      loop_pt       <= 32'd0;
      song_len      <= 32'd0;
      prev_tick     <= '0;
      byte_count    <= 32'd0;
      resume_offset <= 32'd0;
      marker_done   <= 1'b0;
      past_end      <= 1'b0;
      olen          <= 6'd0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
      run_last      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_addr)
          REG_LOOP_EN:  loop_en  <= cfg_data[0];
          REG_LOOP_PT:  loop_pt  <= cfg_data;
          REG_SONG_LEN: song_len <= cfg_data;
          default: ;
        endcase
      end

      if (out_ready && !out_load) out_valid <= 1'b0;

      if (fire) begin
        olen       <= olen + 6'd1;
        byte_count <= byte_count + 32'd1;
        pend_byte  <= gen_byte;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_byte  <= pend_byte;
          run_last  <= 1'b0;
        end
      end

      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            is_fin <= (func == FUNC_FINISH);
            c_tick <= TW'(tick);
            c_ord  <= order;
            c_n    <= (msg_len > 4'(MW)) ? 4'(MW) : msg_len;
            for (int i = 0; i < MW; i++) c_msg[i] <= in_bytes[i];
            st     <= S_DEC;
          end
        end
        S_DEC: begin
          olen <= 6'd0;
          if (drop) begin
            past_end <= 1'b1;
            st       <= S_IDLE;
          end else if (need_ls) begin
            vlq_val     <= delta;
            vlq_first   <= 1'b1;
            prev_tick   <= eff_lp;
            marker_done <= 1'b1;
            st          <= S_LSV;
          end else if (is_fin) begin
            st <= S_ELD;
          end else begin
            vlq_val   <= delta;
            vlq_first <= 1'b1;
            prev_tick <= c_tick;
            st        <= S_EV;
          end
        end
        S_LSV, S_EV, S_EDV: begin
          if (fire) begin
            vlq_first <= 1'b0;
            vlq_idx   <= cur_idx - 4'd1;
            if (vdone) begin
              cnt     <= 4'd0;
              msg_idx <= '0;
              dbl     <= 1'b0;
              if (st == S_LSV) st <= S_LSM;
              else if (st == S_EDV) st <= S_TAIL;
              else st <= (c_n == 4'd0) ? S_FLUSH : S_MSG;
            end
          end
        end
        S_LSM: begin
          if (fire) begin
            cnt <= cnt + 4'd1;
            if (cnt == 4'd3) begin
              resume_offset <= byte_count + 32'd1;
              if (is_fin) begin
                st <= S_ELD;
              end else begin
                vlq_val   <= delta;
                vlq_first <= 1'b1;
                prev_tick <= c_tick;
                st        <= S_EV;
              end
            end
          end
        end
        S_MSG: begin
          if (fire) begin
            if ((mb == B_FE) && !dbl) begin
              dbl <= 1'b1;
            end else begin
              dbl <= 1'b0;
              if (msg_last) st <= S_FLUSH;
              else msg_idx <= msg_idx + IW'(1);
            end
          end
        end
        S_ELD: begin
          vlq_val   <= delta;
          vlq_first <= 1'b1;
          st        <= loop_en ? S_BO1 : S_EDV;
        end
        S_BO1: st <= S_SCAN;
        S_SCAN: begin
          if (bo_rsp.done) begin
            pre_left <= bo_rsp.pre;
            st       <= (bo_rsp.pre != 6'd0) ? S_PRE : S_EDV;
          end
        end
        S_PRE: begin
          if (fire) begin
            pre_left <= pre_left - 6'd1;
            if (pre_left == 6'd1) st <= S_EDV;
          end
        end
        S_TAIL: begin
          if (fire) begin
            cnt <= cnt + 4'd1;
            if (cnt == tail_last) st <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_byte   <= pend_byte;
            run_last   <= 1'b1;
            pend_valid <= 1'b0;
            st         <= S_IDLE;
            if (is_fin) begin
              prev_tick     <= '0;
              byte_count    <= 32'd0;
              resume_offset <= 32'd0;
              marker_done   <= 1'b0;
              past_end      <= 1'b0;
            end
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (st == S_IDLE) |-> !pend_valid) else $error("byte left pending while idle");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    olen <= 6'(MAX_RES)) else $error("result count over limit");

  a_bo_done: assert property (@(posedge clk) disable iff (rst)
    bo_rsp.done |-> (st == S_SCAN)) else $error("back offset done outside scan");

  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
    (st == S_FLUSH) |-> pend_valid) else $error("flush without pending byte");

endmodule

// ===== dv/seq_track_checker.sv =====
// channel monitor, byte stream predictor and result comparison for the track encoder
module seq_track_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [31:0] tick,
  input  logic [1:0]  order,
  input  logic [3:0]  msg_len,
  input  logic [7:0]  msg_b0,
  input  logic [7:0]  msg_b1,
  input  logic [7:0]  msg_b2,
  input  logic [7:0]  msg_b3,
  input  logic [7:0]  msg_b4,
  input  logic [7:0]  msg_b5,
  input  logic [7:0]  msg_b6,
  input  logic [7:0]  msg_b7,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        run_last,
  output int          errors,
  output int          pending
);
  import stenc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  stream_byte_t expected_bytes[$];
  logic [7:0]   run_buf[$];

  logic        loop_en;
  logic [31:0] loop_pt;
  logic [31:0] song_len;
  logic [31:0] last_tick;
  logic [31:0] written;
  logic [31:0] resume_at;
  logic        marker_done;
  logic        past_end;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    errors++;
    if (errors <= 40) $display("mismatch: %s got %02h want %02h", what, got, want);
  endtask

  task automatic emit(input logic [7:0] b);
    if (run_buf.size() < MAX_RES) begin
      run_buf.insert(run_buf.size(), b);
      written++;
    end
  endtask

  function automatic int vlq_size(input logic [31:0] v);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  task automatic emit_delta(input logic [31:0] v);
    logic [63:0] w;
    logic [7:0]  b;
    w = {32'd0, v};
    for (int i = vlq_size(v) - 1; i >= 0; i--) begin
      b = 8'((w >> (7 * i)) & 64'h7F);
      if (i != 0) b = b | B_80;
      emit(b);
    end
  endtask

  function automatic logic [31:0] loop_tick();
    return (loop_pt > song_len) ? song_len : loop_pt;
  endfunction

  function automatic logic [31:0] delta_from_last(input logic [31:0] t);
    return (t >= last_tick) ? t - last_tick : 32'd0;
  endfunction

  task automatic add_loop_marker();
    logic [31:0] lp;
    lp = loop_tick();
    emit_delta(delta_from_last(lp));
    emit(B_FF);
    emit(B_2E);
    emit(B_00);
    emit(B_FF);
    last_tick   = lp;
    resume_at   = written;
    marker_done = 1'b1;
  endtask

  task automatic clear_track();
    last_tick   = '0;
    written     = '0;
    resume_at   = '0;
    marker_done = 1'b0;
    past_end    = 1'b0;
  endtask

  task automatic encode_item();
    logic [7:0]   msg [8];
    int           n;
    logic [31:0]  d;
    logic [31:0]  back;
    int           dl;
    int           maxpre;
    int           pre;
    logic         has_fe;
    stream_byte_t sb;
    msg = '{msg_b0, msg_b1, msg_b2, msg_b3, msg_b4, msg_b5, msg_b6, msg_b7};
    run_buf.delete();
    if (func == FUNC_EVENT) begin
      if (past_end || tick >= song_len) begin
        past_end = 1'b1;
        return;
      end
      n = (msg_len > 4'd8) ? 8 : int'(msg_len);
      if (loop_en && !marker_done &&
          (tick > loop_tick() || (tick == loop_tick() && order >= 2'd2)))
        add_loop_marker();
      emit_delta(delta_from_last(tick));
      for (int i = 0; i < n; i++) begin
        emit(msg[i]);
        if (msg[i] == B_FE) emit(B_FE);
      end
      last_tick = tick;
    end else begin
      if (loop_en && !marker_done) add_loop_marker();
      d = delta_from_last(song_len);
      if (loop_en) begin
        dl     = vlq_size(d);
        maxpre = MAX_RES - run_buf.size() - dl - 11;
        pre    = 0;
        forever begin
          back   = written + 32'(dl + pre) + 32'd8 - resume_at;
          has_fe = (back[31:24] == B_FE) || (back[23:16] == B_FE) ||
                   (back[15:8] == B_FE) || (back[7:0] == B_FE);
          if (!has_fe || pre >= maxpre) break;
          pre++;
        end
        for (int j = 0; j < pre; j++) emit(B_80);
        emit_delta(d);
        emit(B_FF);
        emit(B_2D);
        emit(B_FF);
        emit(B_FF);
        emit(back[31:24]);
        emit(back[23:16]);
        emit(back[15:8]);
        emit(back[7:0]);
        emit(B_00);
        emit(B_FF);
        emit(B_2F);
      end else begin
        emit_delta(d);
        emit(B_FF);
        emit(B_2F);
      end
      clear_track();
    end
    foreach (run_buf[k]) begin
      sb.data = run_buf[k];
      sb.last = (k == run_buf.size() - 1);
      expected_bytes.insert(expected_bytes.size(), sb);
    end
  endtask

  always @(posedge clk) begin
    stream_byte_t want;
    if (rst) begin
      loop_en  = 1'b0;
      loop_pt  = '0;
      song_len = '0;
      clear_track();
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_LOOP_EN:  loop_en = cfg_data[0];
          REG_LOOP_PT:  loop_pt = cfg_data;
          REG_SONG_LEN: song_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) encode_item();
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected byte", out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) report("out_byte", out_byte, want.data);
          if (run_last !== want.last) report("run_last", 8'(run_last), 8'(want.last));
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

// ===== dv/tb_sequence_track_encoder.sv =====
// testbench top for the track encoder: stimulus, receiver stalls, watchdog and verdict
module tb_sequence_track_encoder;
  import stenc_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [31:0] tick;
  logic [1:0]  order;
  logic [3:0]  msg_len;
  logic [7:0]  msg_b0, msg_b1, msg_b2, msg_b3, msg_b4, msg_b5, msg_b6, msg_b7;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        run_last;
  int          chk_errors;
  int          chk_pending;
  int          burst_left;
  int          idle_cycles;
  logic [31:0] track_tick;

  sequence_track_encoder u_top (.*);

  seq_track_checker u_chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data,
    .in_valid, .in_ready, .func, .tick, .order, .msg_len,
    .msg_b0, .msg_b1, .msg_b2, .msg_b3, .msg_b4, .msg_b5, .msg_b6, .msg_b7,
    .out_valid, .out_ready, .out_byte, .run_last,
    .errors(chk_errors), .pending(chk_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] rand_msg_byte();
    return ($urandom_range(0, 3) == 0) ? B_FE : 8'($urandom);
  endfunction

  task automatic send_item(input logic f, input logic [31:0] t, input logic [1:0] ord,
                           input logic [3:0] len, input logic [63:0] bytes);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    func     <= f;
    tick     <= t;
    order    <= ord;
    msg_len  <= len;
    {msg_b0, msg_b1, msg_b2, msg_b3, msg_b4, msg_b5, msg_b6, msg_b7} <= bytes;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_event(input logic [31:0] t, input logic [1:0] ord,
                            input logic [3:0] len, input logic [63:0] bytes);
    send_item(FUNC_EVENT, t, ord, len, bytes);
  endtask

  task automatic send_finish();
    send_item(FUNC_FINISH, 32'($urandom), 2'($urandom), 4'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_rand_event(input logic [31:0] t);
    logic [63:0] bytes;
    for (int i = 0; i < 8; i++) bytes[8 * i +: 8] = rand_msg_byte();
    send_event(t, 2'($urandom), 4'($urandom_range(0, 15)), bytes);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic en, input logic [31:0] lp, input logic [31:0] len);
    write_reg(REG_LOOP_EN, {31'd0, en});
    write_reg(REG_LOOP_PT, lp);
    write_reg(REG_SONG_LEN, len);
    cfg_valid <= 1'b0;
  endtask

  // one track of mostly ascending ticks with some backward and wild ones
  task automatic random_track(input int events);
    int pick;
    track_tick = '0;
    for (int e = 0; e < events; e++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) track_tick = $urandom;
      else if (pick == 1) track_tick = track_tick - $urandom_range(1, 300);
      else if (pick == 2) track_tick = track_tick + $urandom_range(0, 1 << 21);
      else track_tick = track_tick + $urandom_range(0, 200);
      send_rand_event(track_tick);
    end
    if ($urandom_range(0, 7) != 0) send_finish();
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int cyc;
    int mode;
    out_ready = 1'b0;
    cyc = 0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      cyc++;
      if (cyc == 1500) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (cyc % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= (cyc % 4 != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("** sequence_track_encoder: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [31:0] len;
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_addr    <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    func        <= FUNC_EVENT;
    tick        <= '0;
    order       <= '0;
    msg_len     <= '0;
    {msg_b0, msg_b1, msg_b2, msg_b3, msg_b4, msg_b5, msg_b6, msg_b7} <= '0;
    burst_left  = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no looping, widest length: delta sizes, escapes, backward tick, length saturation
    set_config(1'b0, 32'd0, 32'hFFFF_FFFF);
    send_event(32'd0, 2'd0, 4'd1, 64'h00);
    send_event(32'd127, 2'd1, 4'd3, {40'd0, B_FE, B_FE, B_7F});
    send_event(32'hFFFF_FFFE, 2'd3, 4'd8, {8{B_FF}});
    send_event(32'd5, 2'd2, 4'd0, 64'h0);
    send_event(32'd128, 2'd0, 4'd15, {8{B_FE}});
    send_finish();
    wait_drained();

    // looping: marker placement by order class, dropped events
    set_config(1'b1, 32'd100, 32'd1000);
    send_event(32'd50, 2'd1, 4'd2, 64'h4090);
    send_event(32'd100, 2'd0, 4'd3, 64'h7f_3c90);
    send_event(32'd100, 2'd2, 4'd3, 64'h00_3c80);
    send_event(32'd200, 2'd3, 4'd1, 64'hFE);
    send_event(32'd1000, 2'd0, 4'd1, 64'h90);
    send_event(32'd10, 2'd0, 4'd1, 64'h90);
    send_finish();
    wait_drained();

    // loop point past the length, finish before the loop point
    set_config(1'b1, 32'hFFFF_FFFF, 32'd1000);
    send_event(32'd3, 2'd0, 4'd2, 64'hFEFE);
    send_finish();
    wait_drained();
    set_config(1'b1, 32'd0, 32'd0);
    send_event(32'd0, 2'd3, 4'd1, 64'h01);
    send_finish();
    send_finish();
    wait_drained();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 5)
        0:       len = 32'hFFFF_FFFF;
        1:       len = 32'd0;
        default: len = $urandom_range(500, 6000);
      endcase
      set_config(ph % 4 != 3, (ph == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 6000), len);
      random_track((ph == 6) ? 60 : $urandom_range(10, 25));
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("** sequence_track_encoder: PASSED **");
    end else begin
      $display("** sequence_track_encoder: FAILED **");
    end
    $finish;
  end

endmodule
